@@ hw/rtl/lsp_pkg.sv @@
// Shared types and constants for the LIFO stack with promote and sink.
// No dependencies; imported by the channel interfaces and the top level.
`timescale 1ns / 1ps

package lsp_pkg;

  // Fixed field widths of the channels and the register port
  localparam int OPCODE_W = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;
  localparam int CFG_DW   = 32;
  localparam int CFG_AW   = 3;

  localparam logic [COUNT_W-1:0] CAP_RESET = 7'd64;

  // Register index (paddr bit 2)
  localparam logic REG_CAPACITY = 1'b0;

  // Operation codes
  localparam logic [OPCODE_W-1:0] OP_PUSH    = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_POP     = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_PEEK    = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_PROMOTE = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_SINK    = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_SHIFT,
    S_PLACE,
    S_DONE
  } state_t;

endpackage

@@ hw/rtl/lsp_in_if.sv @@
// Operation channel: valid/ready with opcode, push word and position.
// Depends on lsp_pkg for the field widths.
`timescale 1ns / 1ps

interface lsp_in_if;
  import lsp_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [VALUE_W-1:0]  push_value;
  logic [POS_W-1:0]    position;

  modport source (output valid, opcode, push_value, position, input ready);
  modport sink   (input valid, opcode, push_value, position, output ready);
endinterface

@@ hw/rtl/lsp_out_if.sv @@
// Result channel: valid/ready with status, read word and fill count.
// Depends on lsp_pkg for the field widths.
`timescale 1ns / 1ps

interface lsp_out_if;
  import lsp_pkg::*;

  logic               valid;
  logic               ready;
  logic               ok;
  logic [VALUE_W-1:0] read_value;
  logic               is_empty;
  logic [COUNT_W-1:0] entry_count;

  modport source (output valid, ok, read_value, is_empty, entry_count, input ready);
  modport sink   (input valid, ok, read_value, is_empty, entry_count, output ready);
endinterface

@@ hw/rtl/lifo_stack_with_promote.sv @@
// Bounded LIFO stack with promote and sink, built around one sync RAM.
// Depends on lsp_pkg, lsp_in_if and lsp_out_if.
`timescale 1ns / 1ps

// Usage
//   in_chan  : one operation per transfer (push, pop, peek, promote, sink).
//   out_chan : exactly one result per operation, in order: ok, read word,
//              empty flag and fill count after the operation.
//   APB port : capacity register at byte address 0 (paddr bit 2 selects).
//              Write only while no operation is in flight. pready is tied high.
// Operation flow (accept to result in the output register)
//   push, refused or no-op operations : S_DONE directly
//   pop, peek                         : S_READ, S_DONE (one RAM read)
//   promote / sink moving d places    : S_LOAD, S_SHIFT per entry, S_PLACE,
//                                       S_DONE; d <= count - 1
// Each S_SHIFT step does one RAM write and, but on the last step, one RAM
// read. The next operation is accepted in the same cycle as the result
// turns valid.
// One operation is processed at a time; the next one is taken once the
// current result has been placed in the output register, which may still be
// waiting for the receiver.
// Reset (rst_n low, sync) empties the stack and sets capacity to 64. RAM
// contents are not cleared; only entries below the fill count are read.
// Receiver stall: the output register holds its result; a finished
// operation waits in S_DONE until that register frees up.
module lifo_stack_with_promote #(
  parameter int DEPTH      = 64,
  parameter int WORD_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lsp_in_if.sink                      in_chan,
  lsp_out_if.source                   out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lsp_pkg::CFG_AW-1:0]  paddr,
  input  logic [lsp_pkg::CFG_DW-1:0]  pwdata,
  output logic [lsp_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import lsp_pkg::*;

  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_MAX = (1 << COUNT_W) - 1;
  // capacity can never exceed COUNT_MAX, so clamping DEPTH here is exact
  localparam int DEPTH_LIM = (DEPTH < COUNT_MAX) ? DEPTH : COUNT_MAX;
  localparam logic [COUNT_W-1:0] DEPTH_LIM_C = COUNT_W'(DEPTH_LIM);

  state_t state_r, state_nxt;

  logic [COUNT_W-1:0]    cap_r;
  logic [COUNT_W-1:0]    cnt_r, cnt_nxt;
  logic [COUNT_W-1:0]    cur_r;        // entry being overwritten in the shift
  logic [COUNT_W-1:0]    end_r;        // where the moved entry lands
  logic                  dir_up_r;     // promote walks up, sink walks down
  logic [WORD_WIDTH-1:0] moved_r;
  logic                  res_ok_r;
  logic [WORD_WIDTH-1:0] res_rd_r;

  logic                  out_valid_r;
  logic                  out_ok_r;
  logic [VALUE_W-1:0]    out_rd_r;
  logic                  out_empty_r;
  logic [COUNT_W-1:0]    out_cnt_r;

  // stack RAM, one write and one registered read per cycle
  logic [WORD_WIDTH-1:0] mem [DEPTH];
  logic [WORD_WIDTH-1:0] rdata_r;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [WORD_WIDTH-1:0] mem_wdata;

  logic                  in_fire, out_load;
  logic [COUNT_W-1:0]    pos_c, top, limit;
  logic                  has_entries, push_ok, prom_ok, prom_move, sink_ok, sink_move;
  logic                  op_ok;
  logic [COUNT_W-1:0]    step_idx, step2_idx;
  logic                  cfg_wr;

  // ---------------- operation decode ----------------
  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid & in_chan.ready;

  assign pos_c       = {1'b0, in_chan.position};
  assign top         = cnt_r - 1'b1;
  assign limit       = (cap_r < DEPTH_LIM_C) ? cap_r : DEPTH_LIM_C;
  assign has_entries = (cnt_r != '0);
  assign push_ok     = (cnt_r < limit);
  assign prom_ok     = has_entries && (pos_c <= cnt_r);
  // promote of the top entry or at index == count leaves the stack as is
  assign prom_move   = prom_ok && ((pos_c + 1'b1) < cnt_r);
  assign sink_ok     = (pos_c < cnt_r);
  assign sink_move   = sink_ok && (pos_c != '0);

  always_comb begin
    case (in_chan.opcode)
      OP_PUSH:    op_ok = push_ok;
      OP_POP:     op_ok = has_entries;
      OP_PEEK:    op_ok = has_entries;
      OP_PROMOTE: op_ok = prom_ok;
      OP_SINK:    op_ok = sink_ok;
      default:    op_ok = 1'b0;
    endcase
  end

  assign step_idx  = dir_up_r ? (cur_r + 1'b1) : (cur_r - 1'b1);
  assign step2_idx = dir_up_r ? (cur_r + 2'd2) : (cur_r - 2'd2);
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_chan.opcode)
            OP_POP, OP_PEEK: state_nxt = has_entries ? S_READ : S_DONE;
            OP_PROMOTE:      state_nxt = prom_move ? S_LOAD : S_DONE;
            OP_SINK:         state_nxt = sink_move ? S_LOAD : S_DONE;
            default:         state_nxt = S_DONE;
          endcase
        end
      end
      S_READ:  state_nxt = S_DONE;
      S_LOAD:  state_nxt = S_SHIFT;
      S_SHIFT: state_nxt = (step_idx == end_r) ? S_PLACE : S_SHIFT;
      S_PLACE: state_nxt = S_DONE;
      S_DONE:  state_nxt = out_load ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------- RAM controls ----------------
  // In S_SHIFT the read runs two entries ahead of the write, so a read never
  // targets the entry being written in the same cycle; the FSM is the interlock.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_chan.opcode)
            OP_PUSH: begin
              mem_we    = push_ok;
              mem_waddr = AW'(cnt_r);
              mem_wdata = WORD_WIDTH'(in_chan.push_value);
            end
            OP_POP, OP_PEEK: begin
              mem_re    = has_entries;
              mem_raddr = AW'(top);
            end
            OP_PROMOTE: begin
              mem_re    = prom_move;
              mem_raddr = AW'(pos_c);
            end
            OP_SINK: begin
              mem_re    = sink_move;
              mem_raddr = AW'(top);
            end
            default: ;
          endcase
        end
      end
      S_LOAD: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(step_idx);
      end
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(cur_r);
        mem_wdata = rdata_r;
        mem_re    = (step_idx != end_r);
        mem_raddr = AW'(step2_idx);
      end
      S_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(end_r);
        mem_wdata = moved_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  // ---------------- fill count ----------------
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_fire) begin
      if (in_chan.opcode == OP_PUSH && push_ok) begin
        cnt_nxt = cnt_r + 1'b1;
      end else if (in_chan.opcode == OP_POP && has_entries) begin
        cnt_nxt = top;
      end
    end
  end

  // ---------------- config port ----------------
  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? CFG_DW'(cap_r) : '0;

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_wr && paddr[2] == REG_CAPACITY) begin
        cap_r <= pwdata[COUNT_W-1:0];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_ok_r <= op_ok;
          res_rd_r <= '0;
          dir_up_r <= (in_chan.opcode == OP_PROMOTE);
          if (in_chan.opcode == OP_PROMOTE) begin
            cur_r <= pos_c;
            end_r <= top;
          end else begin
            cur_r <= top;
            end_r <= top - pos_c;
          end
        end
      end
      S_READ:  res_rd_r <= rdata_r;
      S_LOAD:  moved_r  <= rdata_r;
      S_SHIFT: cur_r    <= step_idx;
      default: ;
    endcase
    if (out_load) begin
      out_ok_r    <= res_ok_r;
      out_rd_r    <= VALUE_W'(res_rd_r);
      out_empty_r <= (cnt_r == '0);
      out_cnt_r   <= cnt_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.ok          = out_ok_r;
  assign out_chan.read_value  = out_rd_r;
  assign out_chan.is_empty    = out_empty_r;
  assign out_chan.entry_count = out_cnt_r;

  // ---------------- assertions ----------------
`ifndef SYNTHESIS
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_chan.opcode == OP_PUSH && push_ok) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("accepted push did not grow the stack");

  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> (cnt_r == $past(cnt_r)))
    else $error("fill count moved without an accepted operation");

  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (in_fire || state_r == S_SHIFT || state_r == S_PLACE))
    else $error("RAM write outside push or shift");

  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (cur_r < cnt_r && end_r < cnt_r))
    else $error("shift index beyond the fill count");
`endif

endmodule
